/* hdl/stq_pkg.sv */
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted timer queue
// Request/response words, the per-cell slot record and the cell command set.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam logic [15:0] EMPTY_DUE = 16'hFFFF;
   localparam logic [15:0] TPS_RESET = 16'd32768;

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_SECOND = 2'd2;
   localparam logic [1:0] REQ_RUN    = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  task_id;
      logic [15:0] now_time;
      logic [15:0] interval;
      logic        run_once;
   } req_word_type;

   typedef struct packed {
      logic [15:0] head_due;
      logic        ran_valid;
      logic [3:0]  ran_task;
      logic        add_refused;
   } rsp_word_type;

   typedef struct packed {
      logic        valid;
      logic [3:0]  task_id;
      logic [15:0] due;
      logic [15:0] period;
      logic        once;
   } slot_type;

   localparam slot_type SLOT_EMPTY = '{default: '0};

   typedef enum logic [2:0] {
      CMD_HOLD      = 3'd0,
      CMD_DROP_ID   = 3'd1,
      CMD_DROP_HEAD = 3'd2,
      CMD_SECOND    = 3'd3,
      CMD_INSERT    = 3'd4
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type cmd;
      logic [3:0]   task_id;
      slot_type     entry;
      logic [15:0]  tps;
   } cell_ctl_type;

endpackage

/* hdl/stq_cell.sv */
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted timer chain
// Holds one task entry; shifts left on removal, right on insertion, and
// ages its due time on a second rollover.
// ----------------------------------------------------------------------------
module stq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  stq_pkg::cell_ctl_type ctl,
   input  stq_pkg::slot_type     left_slot,
   input  stq_pkg::slot_type     right_slot,
   input  logic                  hit_in,
   input  logic                  le_in,
   output stq_pkg::slot_type     slot_q,
   output stq_pkg::slot_type     slot_d,
   output logic                  hit_out,
   output logic                  le_out
);

   logic              valid_ff;
   stq_pkg::slot_type data_ff;
   stq_pkg::slot_type slot_in;
   logic              match;

   assign slot_q = '{valid: valid_ff, task_id: data_ff.task_id, due: data_ff.due,
                     period: data_ff.period, once: data_ff.once};
   assign slot_d = slot_in;

   always_comb begin
      match   = slot_q.valid && (slot_q.task_id == ctl.task_id);
      hit_out = hit_in | match;
      // sorted chain: cells at or below the new due time form a prefix
      le_out  = slot_q.valid && (slot_q.due <= ctl.entry.due);
      slot_in = slot_q;
      unique case (ctl.cmd)
         stq_pkg::CMD_HOLD: begin
            slot_in = slot_q;
         end
         stq_pkg::CMD_DROP_ID: begin
            if (hit_out) begin
               slot_in = right_slot;
            end
         end
         stq_pkg::CMD_DROP_HEAD: begin
            slot_in = right_slot;
         end
         stq_pkg::CMD_SECOND: begin
            if (slot_q.valid) begin
               slot_in.due = (slot_q.due >= ctl.tps) ? slot_q.due - ctl.tps : 16'd0;
            end
         end
         stq_pkg::CMD_INSERT: begin
            if (le_out) begin
               slot_in = slot_q;
            end else if (le_in) begin
               slot_in = ctl.entry;
            end else begin
               slot_in = left_slot;
            end
         end
         default: begin
            slot_in = slot_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= slot_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= slot_in;
   end

endmodule

/* hdl/sorted_periodic_task_timer_queue_top.sv */
// ----------------------------------------------------------------------------
// sorted_periodic_task_timer_queue_top: sorted periodic task timer queue
// A row of cells keeps the tasks packed and ordered by due time, FIFO on ties.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_ready  req_data (req_word_type)
//   rsp      out  rsp_valid/rsp_ready  rsp_data (rsp_word_type)
//   csr      in   csr_valid/csr_ready  csr_data (ticks_per_second)
//
// Each word makes a drop pass (remove task, pop head or age due times), then
// an insert pass through the cell row; words follow back to back, but
// the insert pass waits while the response register is still full.
// Synchronous reset clears the cell valid bits; no clearing pass is needed.
// csr_ready is always high.
// ----------------------------------------------------------------------------
module sorted_periodic_task_timer_queue_top #(
   parameter int MAX_TASKS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  stq_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output stq_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DROP   = 3'b010,
      ST_INSERT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   stq_pkg::req_word_type req_ff;
   stq_pkg::slot_type     entry_ff, entry_in;
   logic                  ins_ff, ins_in;
   logic                  ran_valid_ff, ran_valid_in;
   logic [3:0]            ran_task_ff, ran_task_in;
   logic                  refused_ff, refused_in;
   logic                  rsp_valid_ff;
   stq_pkg::rsp_word_type rsp_ff;
   logic [15:0]           tps_ff;

   stq_pkg::cell_ctl_type ctl;
   stq_pkg::slot_type     cell_q [MAX_TASKS];
   stq_pkg::slot_type     cell_d [MAX_TASKS];
   logic [MAX_TASKS:0]    hit_chain;
   logic [MAX_TASKS:0]    le_chain;

   logic req_fire, rsp_free, load_rsp;
   logic full, hit_any;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_INSERT) && rsp_free);
   assign req_fire  = req_valid && req_ready;
   assign load_rsp  = (state_ff == ST_INSERT) && rsp_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hit_chain[0] = 1'b0;
   assign le_chain[0]  = 1'b1;
   assign full    = cell_q[MAX_TASKS-1].valid;
   assign hit_any = hit_chain[MAX_TASKS];

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      stq_pkg::slot_type left_slot, right_slot;
      if (i == 0) begin : g_first
         assign left_slot = stq_pkg::SLOT_EMPTY;
      end else begin : g_mid_l
         assign left_slot = cell_q[i-1];
      end
      if (i == MAX_TASKS - 1) begin : g_last
         assign right_slot = stq_pkg::SLOT_EMPTY;
      end else begin : g_mid_r
         assign right_slot = cell_q[i+1];
      end
      stq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .left_slot  (left_slot),
         .right_slot (right_slot),
         .hit_in     (hit_chain[i]),
         .le_in      (le_chain[i]),
         .slot_q     (cell_q[i]),
         .slot_d     (cell_d[i]),
         .hit_out    (hit_chain[i+1]),
         .le_out     (le_chain[i+1])
      );
   end

   // cell commands
   always_comb begin
      ctl.cmd     = stq_pkg::CMD_HOLD;
      ctl.task_id = req_ff.task_id;
      ctl.entry   = entry_ff;
      ctl.tps     = tps_ff;
      priority if (state_ff == ST_DROP) begin
         unique case (req_ff.req_type)
            stq_pkg::REQ_ADD:    ctl.cmd = stq_pkg::CMD_DROP_ID;
            stq_pkg::REQ_REMOVE: ctl.cmd = stq_pkg::CMD_DROP_ID;
            stq_pkg::REQ_SECOND: ctl.cmd = stq_pkg::CMD_SECOND;
            stq_pkg::REQ_RUN:    ctl.cmd = stq_pkg::CMD_DROP_HEAD;
            default:             ctl.cmd = stq_pkg::CMD_HOLD;
         endcase
      end else if (load_rsp && ins_ff) begin
         ctl.cmd = stq_pkg::CMD_INSERT;
      end else begin
         ctl.cmd = stq_pkg::CMD_HOLD;
      end
   end

   // drop pass: decide what the insert pass will put back
   always_comb begin
      entry_in     = entry_ff;
      ins_in       = ins_ff;
      ran_valid_in = ran_valid_ff;
      ran_task_in  = ran_task_ff;
      refused_in   = refused_ff;
      if (state_ff == ST_DROP) begin
         ins_in       = 1'b0;
         ran_valid_in = 1'b0;
         ran_task_in  = 4'd0;
         refused_in   = 1'b0;
         unique case (req_ff.req_type)
            stq_pkg::REQ_ADD: begin
               // a task already present frees its own slot
               refused_in = full && !hit_any;
               ins_in     = !(full && !hit_any);
               entry_in   = '{valid: 1'b1, task_id: req_ff.task_id,
                              due: 16'(req_ff.now_time + req_ff.interval),
                              period: req_ff.interval, once: req_ff.run_once};
            end
            stq_pkg::REQ_RUN: begin
               if (cell_q[0].valid) begin
                  ran_valid_in = 1'b1;
                  ran_task_in  = cell_q[0].task_id;
                  ins_in       = !cell_q[0].once;
                  entry_in     = '{valid: 1'b1, task_id: cell_q[0].task_id,
                                   due: 16'(cell_q[0].due + cell_q[0].period),
                                   period: cell_q[0].period, once: cell_q[0].once};
               end
            end
            default: begin
               ins_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_DROP;
         ST_DROP:   state_in = ST_INSERT;
         ST_INSERT: begin
            if (rsp_free) begin
               state_in = req_fire ? ST_DROP : ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tps_ff       <= stq_pkg::TPS_RESET;
         ins_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         ins_ff   <= ins_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            tps_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      ran_valid_ff <= ran_valid_in;
      ran_task_ff  <= ran_task_in;
      refused_ff   <= refused_in;
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (load_rsp) begin
         rsp_ff.head_due    <= cell_d[0].valid ? cell_d[0].due : stq_pkg::EMPTY_DUE;
         rsp_ff.ran_valid   <= ran_valid_ff;
         rsp_ff.ran_task    <= ran_task_ff;
         rsp_ff.add_refused <= refused_ff;
      end
   end

endmodule

/* hdl/stq_checker.sv */
// ----------------------------------------------------------------------------
// stq_checker: port-level checks for the sorted timer queue
// Watches the response channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module stq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input stq_pkg::rsp_word_type rsp_data
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the word was taken");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   a_run_vs_refuse : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.ran_valid && rsp_data.add_refused))
      else $error("one word both ran a task and refused an add");

   a_idle_task : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ran_valid |-> rsp_data.ran_task == 4'd0)
      else $error("ran_task set without a popped task");

endmodule

bind sorted_periodic_task_timer_queue_top stq_checker u_stq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
